[rtl/drml_pkg.sv]
// Package for the dirty rectangle merge list.
// Holds the beat payload types, register indexes, reset values and the sequencer states.
// Has no dependencies; the top level refers to it by scoped names.
`default_nettype none

package drml_pkg;

   // Edge width of a clamped rectangle; the screen size registers are this wide.
   localparam int COORD_BITS = 13;
   localparam int AREA_BITS  = 2 * COORD_BITS;
   localparam int CSR_BITS   = 25;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] REG_SCREEN_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SCREEN_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_MERGE_THRESHOLD = 2'd2;

   localparam logic [COORD_BITS-1:0] RESET_WIDTH     = 13'd640;
   localparam logic [COORD_BITS-1:0] RESET_HEIGHT    = 13'd480;
   localparam logic [CSR_BITS-1:0]   RESET_THRESHOLD = 25'd8000;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic signed [15:0] rect_top;
      logic signed [15:0] rect_left;
      logic signed [15:0] rect_bottom;
      logic signed [15:0] rect_right;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] out_top;
      logic [COORD_BITS-1:0] out_left;
      logic [COORD_BITS-1:0] out_bottom;
      logic [COORD_BITS-1:0] out_right;
      logic                  list_empty;
      logic                  last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] bottom;
      logic [COORD_BITS-1:0] right;
   } rect_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NAREA,
      ST_UMUL,
      ST_AMUL,
      ST_CMP,
      ST_DECIDE,
      ST_MOVE,
      ST_FL_RD,
      ST_FL_OUT
   } state_type;

   // Clamps a signed edge to the range zero to hi.
   function automatic logic [COORD_BITS-1:0] clamp_edge(input logic signed [15:0] v,
                                                        input logic [COORD_BITS-1:0] hi);
      logic signed [16:0] vx;
      logic signed [16:0] hx;
      logic [COORD_BITS-1:0] res;
      vx = {v[15], v};
      hx = $signed({{(17 - COORD_BITS){1'b0}}, hi});
      if (vx < 17'sd0) begin
         res = '0;
      end else if (vx > hx) begin
         res = hi;
      end else begin
         res = vx[COORD_BITS-1:0];
      end
      return res;
   endfunction

   function automatic logic [COORD_BITS-1:0] min_edge(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [COORD_BITS-1:0] max_edge(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

[rtl/dirty_rect_merge_list.sv]
// Dirty rectangle merge list: clamps, merges and stores dirty rectangles, emits them on flush.
// Depends on drml_pkg for payload types, register indexes and the sequencer states.
//
// Usage: a req beat carries either an add (opcode 0) with a signed rectangle, or a flush
// (opcode 1). An add produces no rsp beat. A flush produces one rsp beat per stored
// rectangle in list order, with last_of_run on the final one, and empties the list; on an
// empty list it produces a single beat with list_empty and last_of_run set and zero edges.
// The csr port writes screen_width, screen_height and merge_threshold with no wait; write
// it only while the block is idle. The block takes one req beat at a time (req_ready is
// high only in the idle state).
// An add computes the new area, then scans each entry with the shared multiplier
// loop (union area, entry area, compare), stopping early on an overlap; each merge that
// grows an entry removes it, moves the last entry into its slot and rescans the list.
// A flush does one memory read and one output load per entry, and waits while the
// receiver holds rsp_ready low.
// The output register lets the next req beat be taken while the last rsp beat waits.
// Reset clears the list count, the output valid and restores the register defaults;
// no clearing pass over the rectangle store is needed.
`default_nettype none

module dirty_rect_merge_list #(
   parameter int MAX_RECTS = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  drml_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output drml_pkg::rsp_type                 rsp_data,
   input  wire                               csr_we,
   input  wire [drml_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire [drml_pkg::CSR_BITS-1:0]      csr_wdata
);

   localparam int IW = $clog2(MAX_RECTS);
   localparam int CW = $clog2(MAX_RECTS + 1);
   localparam int CB = drml_pkg::COORD_BITS;
   localparam int AW = drml_pkg::AREA_BITS;

   drml_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic          best_vld_ff, best_vld_in;
   logic [AW-1:0] best_add_ff, best_add_in;
   drml_pkg::rect_type best_rect_ff, best_rect_in;
   drml_pkg::rect_type n_ff, n_in;
   drml_pkg::rect_type rd_ff;
   logic [AW-1:0] ba_ff, ba_in;
   logic [AW-1:0] u_ff, u_in;
   logic [AW-1:0] ea_ff, ea_in;
   logic [CB-1:0] width_ff, width_in;
   logic [CB-1:0] height_ff, height_in;
   logic [drml_pkg::CSR_BITS-1:0] thr_ff, thr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   drml_pkg::rsp_type rsp_data_ff, rsp_data_in;

   drml_pkg::rect_type mem [MAX_RECTS];
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   drml_pkg::rect_type mem_wdata;
   logic          mem_re;
   logic [IW-1:0] mem_raddr;

   logic [CB-1:0] mul_a, mul_b;
   logic [AW-1:0] mul_p;

   drml_pkg::rect_type clamped, uni, merged;
   logic          clamp_empty, overlap, grows, slot_free, merge_ok, is_last;
   logic signed [AW+1:0] diff;
   logic [AW-1:0] add_area;
   logic [CW-1:0] count_m1;

   // The one shared multiplier; the sequencer picks its operands.
   assign mul_p = mul_a * mul_b;

   assign req_ready = (state_ff == drml_pkg::ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign count_m1  = count_ff - CW'(1);

   always_comb begin
      clamped.top    = drml_pkg::clamp_edge(req_data.rect_top, height_ff);
      clamped.left   = drml_pkg::clamp_edge(req_data.rect_left, width_ff);
      clamped.bottom = drml_pkg::clamp_edge(req_data.rect_bottom, height_ff);
      clamped.right  = drml_pkg::clamp_edge(req_data.rect_right, width_ff);
      clamp_empty = (clamped.bottom <= clamped.top) || (clamped.right <= clamped.left);

      overlap = (n_ff.top < rd_ff.bottom) && (rd_ff.top < n_ff.bottom) &&
                (n_ff.left < rd_ff.right) && (rd_ff.left < n_ff.right);
      uni.top    = drml_pkg::min_edge(n_ff.top, rd_ff.top);
      uni.left   = drml_pkg::min_edge(n_ff.left, rd_ff.left);
      uni.bottom = drml_pkg::max_edge(n_ff.bottom, rd_ff.bottom);
      uni.right  = drml_pkg::max_edge(n_ff.right, rd_ff.right);

      diff = $signed({2'b00, u_ff}) - $signed({2'b00, ea_ff}) - $signed({2'b00, ba_ff});
      add_area = diff[AW+1] ? '0 : diff[AW-1:0];

      merged.top    = drml_pkg::min_edge(n_ff.top, best_rect_ff.top);
      merged.left   = drml_pkg::min_edge(n_ff.left, best_rect_ff.left);
      merged.bottom = drml_pkg::max_edge(n_ff.bottom, best_rect_ff.bottom);
      merged.right  = drml_pkg::max_edge(n_ff.right, best_rect_ff.right);
      grows = (n_ff.top < best_rect_ff.top) || (n_ff.left < best_rect_ff.left) ||
              (n_ff.bottom > best_rect_ff.bottom) || (n_ff.right > best_rect_ff.right);

      merge_ok = (count_ff != '0) &&
                 ((best_vld_ff && ({1'b0, thr_ff} >= best_add_ff)) ||
                  (count_ff == CW'(MAX_RECTS)));
      is_last = (idx_ff == count_m1[IW-1:0]);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      best_idx_in  = best_idx_ff;
      best_vld_in  = best_vld_ff;
      best_add_in  = best_add_ff;
      best_rect_in = best_rect_ff;
      n_in         = n_ff;
      ba_in        = ba_ff;
      u_in         = u_ff;
      ea_in        = ea_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IW-1:0];
      mem_wdata    = n_ff;
      mem_re       = 1'b0;
      mem_raddr    = count_m1[IW-1:0];
      mul_a        = n_ff.right - n_ff.left;
      mul_b        = n_ff.bottom - n_ff.top;

      width_in  = (csr_we && csr_index == drml_pkg::REG_SCREEN_WIDTH) ?
                  csr_wdata[CB-1:0] : width_ff;
      height_in = (csr_we && csr_index == drml_pkg::REG_SCREEN_HEIGHT) ?
                  csr_wdata[CB-1:0] : height_ff;
      thr_in    = (csr_we && csr_index == drml_pkg::REG_MERGE_THRESHOLD) ?
                  csr_wdata : thr_ff;

      case (state_ff)
         drml_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.opcode == drml_pkg::OP_FLUSH) begin
                  idx_in   = '0;
                  state_in = drml_pkg::ST_FL_RD;
               end else if (!clamp_empty) begin
                  n_in     = clamped;
                  state_in = drml_pkg::ST_NAREA;
               end
            end
         end
         drml_pkg::ST_NAREA: begin
            // Area of the new rectangle, then start the scan at the highest index.
            ba_in       = mul_p;
            best_vld_in = 1'b0;
            if (count_ff == '0) begin
               state_in = drml_pkg::ST_DECIDE;
            end else begin
               mem_re   = 1'b1;
               idx_in   = count_m1[IW-1:0];
               state_in = drml_pkg::ST_UMUL;
            end
         end
         drml_pkg::ST_UMUL: begin
            mul_a = uni.right - uni.left;
            mul_b = uni.bottom - uni.top;
            if (overlap) begin
               best_idx_in  = idx_ff;
               best_rect_in = rd_ff;
               best_add_in  = '0;
               best_vld_in  = 1'b1;
               state_in     = drml_pkg::ST_DECIDE;
            end else begin
               u_in     = mul_p;
               state_in = drml_pkg::ST_AMUL;
            end
         end
         drml_pkg::ST_AMUL: begin
            mul_a    = rd_ff.right - rd_ff.left;
            mul_b    = rd_ff.bottom - rd_ff.top;
            ea_in    = mul_p;
            state_in = drml_pkg::ST_CMP;
         end
         drml_pkg::ST_CMP: begin
            // Strict compare keeps the higher index on a tie.
            if (!best_vld_ff || (add_area < best_add_ff)) begin
               best_idx_in  = idx_ff;
               best_rect_in = rd_ff;
               best_add_in  = add_area;
               best_vld_in  = 1'b1;
            end
            if (idx_ff == '0) begin
               state_in = drml_pkg::ST_DECIDE;
            end else begin
               idx_in    = idx_ff - IW'(1);
               mem_re    = 1'b1;
               mem_raddr = idx_ff - IW'(1);
               state_in  = drml_pkg::ST_UMUL;
            end
         end
         drml_pkg::ST_DECIDE: begin
            if (!merge_ok) begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = drml_pkg::ST_IDLE;
            end else if (count_ff == CW'(1)) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = merged;
               state_in  = drml_pkg::ST_IDLE;
            end else if (!grows) begin
               state_in = drml_pkg::ST_IDLE;
            end else begin
               // The chosen entry is taken out (the last entry moves into its slot) and
               // the union goes round the scan again.
               n_in     = merged;
               mem_re   = 1'b1;
               state_in = drml_pkg::ST_MOVE;
            end
         end
         drml_pkg::ST_MOVE: begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_ff;
            mem_wdata = rd_ff;
            count_in  = count_m1;
            state_in  = drml_pkg::ST_NAREA;
         end
         drml_pkg::ST_FL_RD: begin
            if (count_ff == '0) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{out_top: '0, out_left: '0, out_bottom: '0,
                                   out_right: '0, list_empty: 1'b1, last_of_run: 1'b1};
                  state_in     = drml_pkg::ST_IDLE;
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff;
               state_in  = drml_pkg::ST_FL_OUT;
            end
         end
         drml_pkg::ST_FL_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_top: rd_ff.top, out_left: rd_ff.left,
                                out_bottom: rd_ff.bottom, out_right: rd_ff.right,
                                list_empty: 1'b0, last_of_run: is_last};
               if (is_last) begin
                  count_in = '0;
                  state_in = drml_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = drml_pkg::ST_FL_RD;
               end
            end
         end
         default: begin
            state_in = drml_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drml_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= drml_pkg::RESET_WIDTH;
         height_ff    <= drml_pkg::RESET_HEIGHT;
         thr_ff       <= drml_pkg::RESET_THRESHOLD;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         thr_ff       <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      best_idx_ff  <= best_idx_in;
      best_vld_ff  <= best_vld_in;
      best_add_ff  <= best_add_in;
      best_rect_ff <= best_rect_in;
      n_ff         <= n_in;
      ba_ff        <= ba_in;
      u_ff         <= u_in;
      ea_ff        <= ea_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Rectangle store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_raddr];
      end
   end

endmodule

`default_nettype wire

[test/rect_list_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the dirty rectangle merge list: watches the req, rsp and csr ports, keeps
// its own copy of the list and the registers, and compares every rsp beat in order.
// Depends on drml_pkg for the beat payload types, register indexes and reset values.

module rect_list_checker #(
   parameter int MAX_RECTS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_ready,
   input  drml_pkg::req_type                req_data,
   input  wire                              rsp_valid,
   input  wire                              rsp_ready,
   input  drml_pkg::rsp_type                rsp_data,
   input  wire                              csr_we,
   input  wire [drml_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire [drml_pkg::CSR_BITS-1:0]     csr_wdata,
   output int                               failures,
   output int                               outstanding
);

   typedef struct {
      int top;
      int left;
      int bottom;
      int right;
   } box_type;

   int scr_w;
   int scr_h;
   int merge_limit;
   box_type boxes [MAX_RECTS];
   int box_cnt;
   drml_pkg::rsp_type flush_beats [$];

   function automatic int clip(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit overlap(box_type a, box_type b);
      return a.top < b.bottom && b.top < a.bottom && a.left < b.right && b.left < a.right;
   endfunction

   // Pixels that the bounding box of a and b covers beyond the two areas.
   function automatic longint union_gain(box_type a, box_type b);
      longint t, l, bo, r, d;
      t  = (a.top < b.top) ? a.top : b.top;
      l  = (a.left < b.left) ? a.left : b.left;
      bo = (a.bottom > b.bottom) ? a.bottom : b.bottom;
      r  = (a.right > b.right) ? a.right : b.right;
      d  = (r - l) * (bo - t)
           - longint'(a.right - a.left) * longint'(a.bottom - a.top)
           - longint'(b.right - b.left) * longint'(b.bottom - b.top);
      return (d < 0) ? 0 : d;
   endfunction

   function automatic void insert_box(box_type n);
      longint best_gain;
      longint gain;
      int best;
      bit grows;
      bit done;
      box_type d;
      done = 1'b0;
      while (!done) begin
         best_gain = 64'sh7FFF_FFFF_FFFF_FFFF;
         best = 0;
         // Scan from the highest index down; an overlap ends the search at once.
         for (int i = box_cnt - 1; i >= 0; i--) begin
            if (overlap(n, boxes[i])) begin
               best_gain = 0;
               best = i;
               break;
            end
            gain = union_gain(n, boxes[i]);
            if (gain < best_gain) begin
               best_gain = gain;
               best = i;
            end
         end
         if (box_cnt > 0 && (best_gain <= longint'(merge_limit) || box_cnt == MAX_RECTS)) begin
            if (box_cnt == 1) begin
               if (n.top < boxes[0].top) boxes[0].top = n.top;
               if (n.left < boxes[0].left) boxes[0].left = n.left;
               if (n.bottom > boxes[0].bottom) boxes[0].bottom = n.bottom;
               if (n.right > boxes[0].right) boxes[0].right = n.right;
               done = 1'b1;
            end else begin
               d = boxes[best];
               grows = 1'b0;
               if (d.top <= n.top) n.top = d.top; else grows = 1'b1;
               if (d.left <= n.left) n.left = d.left; else grows = 1'b1;
               if (d.bottom >= n.bottom) n.bottom = d.bottom; else grows = 1'b1;
               if (d.right >= n.right) n.right = d.right; else grows = 1'b1;
               if (!grows) begin
                  done = 1'b1;
               end else begin
                  // The chosen entry leaves the list and the grown union is offered again.
                  boxes[best] = boxes[box_cnt - 1];
                  box_cnt--;
               end
            end
         end else begin
            if (box_cnt < MAX_RECTS) begin
               boxes[box_cnt] = n;
               box_cnt++;
            end
            done = 1'b1;
         end
      end
   endfunction

   function automatic void predict_beat(drml_pkg::req_type beat);
      box_type n;
      drml_pkg::rsp_type o;
      if (beat.opcode == drml_pkg::OP_ADD) begin
         n.top    = clip(int'($signed(beat.rect_top)), scr_h);
         n.left   = clip(int'($signed(beat.rect_left)), scr_w);
         n.bottom = clip(int'($signed(beat.rect_bottom)), scr_h);
         n.right  = clip(int'($signed(beat.rect_right)), scr_w);
         if (n.bottom > n.top && n.right > n.left) insert_box(n);
      end else if (box_cnt == 0) begin
         o = '0;
         o.list_empty = 1'b1;
         o.last_of_run = 1'b1;
         flush_beats.insert(flush_beats.size(), o);
      end else begin
         for (int k = 0; k < box_cnt; k++) begin
            o.out_top     = drml_pkg::COORD_BITS'(boxes[k].top);
            o.out_left    = drml_pkg::COORD_BITS'(boxes[k].left);
            o.out_bottom  = drml_pkg::COORD_BITS'(boxes[k].bottom);
            o.out_right   = drml_pkg::COORD_BITS'(boxes[k].right);
            o.list_empty  = 1'b0;
            o.last_of_run = (k == box_cnt - 1);
            flush_beats.insert(flush_beats.size(), o);
         end
         box_cnt = 0;
      end
   endfunction

   always @(posedge clock) begin
      drml_pkg::rsp_type want;
      if (reset) begin
         scr_w = int'(drml_pkg::RESET_WIDTH);
         scr_h = int'(drml_pkg::RESET_HEIGHT);
         merge_limit = int'(drml_pkg::RESET_THRESHOLD);
         box_cnt = 0;
         failures = 0;
         flush_beats.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               drml_pkg::REG_SCREEN_WIDTH:    scr_w = int'(csr_wdata[drml_pkg::COORD_BITS-1:0]);
               drml_pkg::REG_SCREEN_HEIGHT:   scr_h = int'(csr_wdata[drml_pkg::COORD_BITS-1:0]);
               drml_pkg::REG_MERGE_THRESHOLD: merge_limit = int'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (flush_beats.size() == 0) begin
               if (failures < 10)
                  $display({"rsp beat with nothing expected: ",
                            "t=%0d l=%0d b=%0d r=%0d e=%0b last=%0b"},
                           rsp_data.out_top, rsp_data.out_left, rsp_data.out_bottom,
                           rsp_data.out_right, rsp_data.list_empty, rsp_data.last_of_run);
               failures++;
            end else begin
               want = flush_beats.pop_front();
               if (rsp_data.out_top !== want.out_top || rsp_data.out_left !== want.out_left ||
                   rsp_data.out_bottom !== want.out_bottom ||
                   rsp_data.out_right !== want.out_right ||
                   rsp_data.list_empty !== want.list_empty ||
                   rsp_data.last_of_run !== want.last_of_run) begin
                  if (failures < 10) begin
                     $display("rsp mismatch: expected t=%0d l=%0d b=%0d r=%0d e=%0b last=%0b",
                              want.out_top, want.out_left, want.out_bottom, want.out_right,
                              want.list_empty, want.last_of_run);
                     $display("              actual   t=%0d l=%0d b=%0d r=%0d e=%0b last=%0b",
                              rsp_data.out_top, rsp_data.out_left, rsp_data.out_bottom,
                              rsp_data.out_right, rsp_data.list_empty, rsp_data.last_of_run);
                  end
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) predict_beat(req_data);
      end
      outstanding <= flush_beats.size();
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the dirty rectangle merge list testbench: clock, reset, register writes, req
// stimulus and rsp back-pressure; the verdict comes from rect_list_checker.
// Depends on drml_pkg, dirty_rect_merge_list and rect_list_checker.

module testbench;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 600;
   localparam int HOLD_CYCLES   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   drml_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   drml_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [drml_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [drml_pkg::CSR_BITS-1:0] csr_wdata = '0;
   int failures;
   int outstanding;

   bit calm = 1'b0;
   bit hold_trigger = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int scr_w_now = 640;
   int scr_h_now = 480;

   always #2 clock = ~clock;

   dirty_rect_merge_list uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   rect_list_checker list_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .failures(failures),
      .outstanding(outstanding)
   );

   // Receiver: random stalls, none while calm, and one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 16);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic drml_pkg::req_type rect_add(int t, int l, int b, int r);
      drml_pkg::req_type x;
      x.opcode = drml_pkg::OP_ADD;
      x.rect_top = 16'(t);
      x.rect_left = 16'(l);
      x.rect_bottom = 16'(b);
      x.rect_right = 16'(r);
      return x;
   endfunction

   // The edges of a flush beat are ignored, so they carry random bits.
   function automatic drml_pkg::req_type flush_req();
      drml_pkg::req_type x;
      x.opcode = drml_pkg::OP_FLUSH;
      x.rect_top = 16'($urandom);
      x.rect_left = 16'($urandom);
      x.rect_bottom = 16'($urandom);
      x.rect_right = 16'($urandom);
      return x;
   endfunction

   function automatic drml_pkg::req_type rand_req();
      drml_pkg::req_type x;
      int w, h, t, l, dh, dw, sel;
      w = (scr_w_now > 0) ? scr_w_now : 64;
      h = (scr_h_now > 0) ? scr_h_now : 64;
      sel = int'($urandom_range(99));
      if (sel < 8) return flush_req();
      if (sel < 18) begin
         x.opcode = drml_pkg::OP_ADD;
         x.rect_top = 16'($urandom);
         x.rect_left = 16'($urandom);
         x.rect_bottom = 16'($urandom);
         x.rect_right = 16'($urandom);
         return x;
      end
      // Mostly small rectangles near the screen, some reaching past its edges.
      t = int'($urandom_range(0, h + 8)) - 4;
      l = int'($urandom_range(0, w + 8)) - 4;
      if (sel < 90) begin
         dh = int'($urandom_range(1, h / 4 + 1));
         dw = int'($urandom_range(1, w / 4 + 1));
      end else begin
         dh = int'($urandom_range(1, h));
         dw = int'($urandom_range(1, w));
      end
      if (sel < 22) dh = -dh;
      return rect_add(t, l, t + dh, l + dw);
   endfunction

   task automatic send(input drml_pkg::req_type beat);
      if (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // An add gives no beat, so the block may still be busy after the last flush beat.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int w, input int h, input int thr);
      csr_we <= 1'b1;
      csr_index <= drml_pkg::REG_SCREEN_WIDTH;
      csr_wdata <= drml_pkg::CSR_BITS'(w);
      @(posedge clock);
      csr_index <= drml_pkg::REG_SCREEN_HEIGHT;
      csr_wdata <= drml_pkg::CSR_BITS'(h);
      @(posedge clock);
      csr_index <= drml_pkg::REG_MERGE_THRESHOLD;
      csr_wdata <= drml_pkg::CSR_BITS'(thr);
      @(posedge clock);
      csr_we <= 1'b0;
      scr_w_now = w & 'h1FFF;
      scr_h_now = h & 'h1FFF;
   endtask

   task automatic run_phase(input int w, input int h, input int thr, input int n);
      configure(w, h, thr);
      repeat (n) send(rand_req());
      send(flush_req());
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset register values.
      send(flush_req());
      send(rect_add(-32768, -32768, 32767, 32767));
      send(rect_add(10, 10, 20, 20));
      send(flush_req());
      send(rect_add(5, 5, 5, 50));
      send(rect_add(-100, -100, -1, -1));
      send(rect_add(0, 700, 50, 800));
      send(rect_add(0, 0, 10, 10));
      send(rect_add(0, 12, 10, 20));
      send(rect_add(400, 600, 410, 610));
      send(rect_add(0, 30, 10, 40));
      send(rect_add(5, 5, 8, 30));
      send(rect_add(8, 35, 20, 45));
      send(rect_add(200, 200, 300, 300));
      send(rect_add(32767, 32767, -32768, -32768));
      send(flush_req());
      send(rect_add(0, 0, 1, 1));
      send(rect_add(479, 639, 480, 640));
      send(flush_req());
      send(rect_add(-1, -1, 3, 3));
      send(rect_add(1, 1, 2, 2));
      send(flush_req());
      drain();

      run_phase(640, 480, 8000, 60);

      // Fill the list with separated squares, force a merge on the full list, then hold
      // off the receiver during the flush while further beats keep coming.
      configure(64, 48, 0);
      for (int i = 0; i < 16; i++)
         send(rect_add((i / 4) * 12, (i % 4) * 16, (i / 4) * 12 + 2, (i % 4) * 16 + 2));
      send(rect_add(44, 60, 46, 62));
      send(flush_req());
      hold_trigger <= ~hold_trigger;
      repeat (50) send(rand_req());
      send(flush_req());
      drain();

      calm <= 1'b1;
      run_phase(8191, 8191, 'h1FFFFFF, 40);
      calm <= 1'b0;
      run_phase(0, 480, 8000, 15);
      run_phase(320, 0, 0, 10);
      run_phase(1, 1, 0, 20);
      run_phase(4096, 4096, 16777216, 50);
      run_phase(100, 80, 50, 75);
      run_phase(2, 4096, 0, 40);

      if (failures == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
